>>> design/sssc_pkg.sv
package sssc_pkg;

  // Timer and register widths
  localparam int TIMER_BITS = 16;
  localparam int ON_BITS    = 10;
  localparam int CNT_BITS   = 8;

  // Reset values and on-time limits
  localparam logic [TIMER_BITS-1:0] TARGET_PERIOD_RST = 16'd6099;
  localparam logic [TIMER_BITS-1:0] START_PERIOD_RST  = 16'd9999;
  localparam logic [TIMER_BITS-1:0] REF_INTERVAL_RST  = 16'd9999;
  localparam logic [CNT_BITS-1:0]   ALIGN_TICKS_RST   = 8'd100;
  localparam logic [CNT_BITS-1:0]   UPDATE_EVERY_RST  = 8'd100;
  localparam logic [ON_BITS-1:0]    ON_ALIGN          = 10'd699;
  localparam logic [ON_BITS-1:0]    ON_RUN            = 10'd349;
  localparam logic [ON_BITS-1:0]    ON_MAX            = 10'd449;
  localparam logic [ON_BITS-1:0]    ON_MIN            = 10'd309;
  localparam logic [ON_BITS-1:0]    ON_DOWN_STEP      = 10'd5;
  localparam logic [TIMER_BITS-1:0] CAL_WINDOW        = 16'd5;
  localparam logic [TIMER_BITS-1:0] REG_MARGIN        = 16'd100;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_TICK   = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_ALIGN     = 3'd1,
    PH_RAMP      = 3'd2,
    PH_CALIBRATE = 3'd3,
    PH_REGULATE  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    CFG_TARGET_PERIOD = 2'd0,
    CFG_START_PERIOD  = 2'd1,
    CFG_ALIGN_TICKS   = 2'd2,
    CFG_UPDATE_EVERY  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    op_t                   op;
    logic [2:0]            bemf_bits;
    logic [TIMER_BITS-1:0] elapsed;
  } in_req_t;

  typedef struct packed {
    phase_t                phase;
    logic [2:0]            step;
    logic [5:0]            drive_mask;
    logic [ON_BITS-1:0]    on_time;
    logic [TIMER_BITS-1:0] pwm_period;
    logic                  commutated;
    logic                  restart_elapsed;
  } out_req_t;

  // Driver pattern for each commutation step; nothing for unused codes
  function automatic logic [5:0] step_mask(input logic [2:0] s);
    logic [5:0] m;
    case (s)
      3'd0:    m = 6'h18;
      3'd1:    m = 6'h09;
      3'd2:    m = 6'h21;
      3'd3:    m = 6'h24;
      3'd4:    m = 6'h06;
      3'd5:    m = 6'h12;
      default: m = 6'h00;
    endcase
    return m;
  endfunction

endpackage

>>> design/sensorless_six_step_commutator.sv
// Six-step sensorless commutator. Each request (start, PWM tick or back-EMF
// sample) updates the control state at the accepting edge; its result goes to
// the output register, or to a one-deep skid stage behind it while the output
// is stalled. A request can be taken every cycle while the skid stage is not
// full (in_stall rises only then). Registers must be written through the cfg
// port (always ready) while no request is in flight; this is not enforced.
module sensorless_six_step_commutator
  import sssc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_req_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_req_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  logic [TIMER_BITS-1:0] cfg_data
);

  // Configuration registers
  logic [TIMER_BITS-1:0] target_period_r, start_period_r;
  logic [CNT_BITS-1:0]   align_ticks_r, update_every_r;

  // Control state
  phase_t                phase_r, phase_nxt;
  logic [2:0]            step_r, step_nxt;
  logic                  last_bemf_r, last_bemf_nxt;
  logic [CNT_BITS-1:0]   align_cnt_r, align_cnt_nxt;
  logic [TIMER_BITS-1:0] period_r, period_nxt;
  logic [ON_BITS-1:0]    high_time_r, high_time_nxt;
  logic [TIMER_BITS-1:0] ref_int_r, ref_int_nxt;
  logic [CNT_BITS-1:0]   adj_cnt_r, adj_cnt_nxt;

  // Output register and skid stage
  logic     out_valid_r, skid_valid_r;
  out_req_t out_data_r, skid_data_r;
  out_req_t res;

  logic in_acc, out_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid & ~in_stall;
  assign out_take  = out_valid_r & ~out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_period_r <= TARGET_PERIOD_RST;
      start_period_r  <= START_PERIOD_RST;
      align_ticks_r   <= ALIGN_TICKS_RST;
      update_every_r  <= UPDATE_EVERY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TARGET_PERIOD: target_period_r <= cfg_data;
        CFG_START_PERIOD:  start_period_r  <= cfg_data;
        CFG_ALIGN_TICKS:   align_ticks_r   <= cfg_data[CNT_BITS-1:0];
        CFG_UPDATE_EVERY:  update_every_r  <= cfg_data[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Request evaluation
  always_comb begin
    logic                  bemf_bit;
    logic [CNT_BITS-1:0]   align_inc;
    logic [CNT_BITS-1:0]   adj_inc;
    logic [TIMER_BITS:0]   e_ext;
    logic                  cal_hit;
    logic                  reg_up, reg_down;
    logic                  commutated, restart;
    logic                  tick_drive;
    logic [2:0]            step_plus;

    phase_nxt     = phase_r;
    step_nxt      = step_r;
    last_bemf_nxt = last_bemf_r;
    align_cnt_nxt = align_cnt_r;
    period_nxt    = period_r;
    high_time_nxt = high_time_r;
    ref_int_nxt   = ref_int_r;
    adj_cnt_nxt   = adj_cnt_r;
    commutated    = 1'b0;
    restart       = 1'b0;
    tick_drive    = 1'b0;

    // comparator bit chosen by step modulo three
    case (step_r)
      3'd0, 3'd3: bemf_bit = in_data.bemf_bits[0];
      3'd1, 3'd4: bemf_bit = in_data.bemf_bits[1];
      default:    bemf_bit = in_data.bemf_bits[2];
    endcase
    step_plus = (step_r == 3'd5) ? 3'd0 : step_r + 3'd1;
    align_inc = (align_cnt_r < align_ticks_r) ? align_cnt_r + 8'd1 : align_cnt_r;
    adj_inc   = adj_cnt_r + 8'd1;

    // calibrate window and regulate comparisons
    e_ext   = {1'b0, in_data.elapsed};
    cal_hit = (in_data.elapsed >= CAL_WINDOW) &&
              (ref_int_r > in_data.elapsed - CAL_WINDOW) &&
              ({1'b0, ref_int_r} < e_ext + {1'b0, CAL_WINDOW});
    reg_up   = (ref_int_r >= REG_MARGIN) && (in_data.elapsed > ref_int_r - REG_MARGIN);
    reg_down = ~reg_up && (in_data.elapsed < ref_int_r);

    unique case (in_data.op)
      OP_START: begin
        if (phase_r == PH_IDLE) begin
          phase_nxt     = PH_ALIGN;
          step_nxt      = 3'd3;
          align_cnt_nxt = '0;
          high_time_nxt = ON_ALIGN;
          period_nxt    = start_period_r;
        end
      end
      OP_TICK: begin
        tick_drive = (phase_r != PH_IDLE);
        if (phase_r == PH_ALIGN) begin
          align_cnt_nxt = align_inc;
          if (align_inc >= align_ticks_r) begin
            align_cnt_nxt = '0;
            if (step_r == 3'd3 || step_r == 3'd4) begin
              step_nxt = step_r + 3'd1;
            end else begin
              step_nxt      = 3'd0;
              high_time_nxt = ON_RUN;
              phase_nxt     = PH_RAMP;
              restart       = 1'b1;
            end
          end
        end
      end
      OP_SAMPLE: begin
        if ((phase_r == PH_RAMP || phase_r == PH_CALIBRATE || phase_r == PH_REGULATE) &&
            bemf_bit != last_bemf_r) begin
          last_bemf_nxt = bemf_bit;
          step_nxt      = step_plus;
          commutated    = 1'b1;
          if (phase_r == PH_RAMP) begin
            if (period_r > target_period_r) begin
              period_nxt = period_r - 16'd1;
            end else begin
              phase_nxt = PH_CALIBRATE;
              restart   = 1'b1;
            end
          end else begin
            restart = 1'b1;
            if (phase_r == PH_CALIBRATE) begin
              if (cal_hit) phase_nxt = PH_REGULATE;
              else         ref_int_nxt = ref_int_r - 16'd1;
            end else if (reg_up || reg_down) begin
              // counted on-time nudge
              if (adj_inc == update_every_r) begin
                adj_cnt_nxt = '0;
                if (reg_up) begin
                  if (high_time_r < ON_MAX) high_time_nxt = high_time_r + 10'd1;
                end else begin
                  if (high_time_r > ON_MIN) high_time_nxt = high_time_r - ON_DOWN_STEP;
                end
              end else begin
                adj_cnt_nxt = adj_inc;
              end
            end else begin
              high_time_nxt = ON_RUN;
            end
          end
        end
      end
      default: ;
    endcase

    res.phase           = phase_nxt;
    res.step            = step_nxt;
    res.drive_mask      = tick_drive ? step_mask(step_r) :
                          (phase_nxt != PH_IDLE) ? step_mask(step_nxt) : 6'h00;
    res.on_time         = high_time_nxt;
    res.pwm_period      = period_nxt;
    res.commutated      = commutated;
    res.restart_elapsed = restart;
  end

  // State update on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      step_r      <= '0;
      last_bemf_r <= 1'b0;
      align_cnt_r <= '0;
      period_r    <= START_PERIOD_RST;
      high_time_r <= ON_ALIGN;
      ref_int_r   <= REF_INTERVAL_RST;
      adj_cnt_r   <= '0;
    end else if (in_acc) begin
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      last_bemf_r <= last_bemf_nxt;
      align_cnt_r <= align_cnt_nxt;
      period_r    <= period_nxt;
      high_time_r <= high_time_nxt;
      ref_int_r   <= ref_int_nxt;
      adj_cnt_r   <= adj_cnt_nxt;
    end
  end

  // Output register and skid control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take || !out_valid_r) begin
      out_valid_r  <= skid_valid_r | in_acc;
      skid_valid_r <= 1'b0;
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_take || !out_valid_r) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (in_acc) begin
      skid_data_r <= res;
    end
  end

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a result while output register is empty");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= 3'd5)
    else $error("commutation step out of range");

  a_commutate_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.commutated) |->
      (out_data_r.phase == PH_RAMP || out_data_r.phase == PH_CALIBRATE ||
       out_data_r.phase == PH_REGULATE))
    else $error("commutation reported outside a running phase");

  a_idle_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.phase == PH_IDLE) |-> (out_data_r.drive_mask == 6'h00))
    else $error("drivers raised while idle");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_take) |=> skid_valid_r && $stable(skid_data_r))
    else $error("skid stage lost or changed a held result");

endmodule

>>> tb/sensorless_six_step_commutator_tb.sv
module sensorless_six_step_commutator_tb;
  import sssc_pkg::*;

  // Own copies of the block's constants
  localparam logic [35:0] STEP_DRIVE = {6'h12, 6'h06, 6'h24, 6'h21, 6'h09, 6'h18};
  localparam logic [9:0]  ON_ALIGN_T = 10'd699;
  localparam logic [9:0]  ON_RUN_T   = 10'd349;
  localparam logic [9:0]  ON_CEIL    = 10'd449;
  localparam logic [9:0]  ON_FLOOR   = 10'd309;
  localparam logic [9:0]  ON_DROP    = 10'd5;
  localparam logic [15:0] REG_SPAN   = 16'd100;
  localparam int LATENCY_PAUSE  = 4;
  localparam int TIMEOUT_CYCLES = 500_000;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_req_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_req_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = CFG_TARGET_PERIOD;
  logic [TIMER_BITS-1:0] cfg_data  = '0;

  // Predicted motor state and register copy
  phase_t     cm_phase;
  logic [2:0] cm_step;
  logic       cm_last_bemf;
  logic [7:0] cm_align_cnt;
  logic [15:0] cm_period;
  logic [9:0] cm_on_time;
  logic [15:0] cm_ref;
  logic [7:0] cm_adjust_cnt;
  logic [15:0] r_target, r_start;
  logic [7:0] r_align, r_update;

  out_req_t predicted_reports[$];
  int mismatches  = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  sensorless_six_step_commutator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  function automatic void set_idling(int mode);
    case (mode)
      0:       begin tx_idle_pct = 31; rx_idle_pct = 48; end
      1:       begin tx_idle_pct = 48; rx_idle_pct = 31; end
      default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
    endcase
  endfunction

  function automatic logic [5:0] drive_for(logic [2:0] s);
    return (s < 3'd6) ? STEP_DRIVE[s*6 +: 6] : 6'h00;
  endfunction

  // Calibration holds when elapsed is at least 5 and less than 5 from the interval
  function automatic bit in_window(logic [15:0] ref_iv, logic [15:0] e);
    return (e >= 16'd5) && (int'(ref_iv) > int'(e) - 5) && (int'(ref_iv) < int'(e) + 5);
  endfunction

  task automatic reset_model();
    r_target = 16'd6099; r_start = 16'd9999; r_align = 8'd100; r_update = 8'd100;
    cm_phase = PH_IDLE; cm_step = '0; cm_last_bemf = 1'b0; cm_align_cnt = '0;
    cm_period = 16'd9999; cm_on_time = ON_ALIGN_T; cm_ref = 16'd9999; cm_adjust_cnt = '0;
  endtask

  // Counted on-time nudge, applied once every r_update qualifying commutations (every 256 when r_update is zero)
  task automatic nudge_on_time(bit up);
    cm_adjust_cnt = cm_adjust_cnt + 8'd1;
    if (cm_adjust_cnt == r_update) begin
      if (up) begin
        if (cm_on_time < ON_CEIL) cm_on_time = cm_on_time + 10'd1;
      end else if (cm_on_time > ON_FLOOR) begin
        cm_on_time = cm_on_time - ON_DROP;
      end
      cm_adjust_cnt = '0;
    end
  endtask

  // Advance the predicted state by one request and form the expected result
  task automatic step_commutator(input in_req_t it, output out_req_t res);
    logic [5:0] drive;
    bit         drive_set, comm, restart;
    logic       sel;
    drive = '0; drive_set = 0; comm = 0; restart = 0;
    case (it.op)
      OP_START: begin
        if (cm_phase == PH_IDLE) begin
          cm_phase = PH_ALIGN; cm_step = 3'd3; cm_align_cnt = '0;
          cm_on_time = ON_ALIGN_T; cm_period = r_start;
        end
      end
      OP_TICK: begin
        if (cm_phase != PH_IDLE) begin
          drive = drive_for(cm_step);
          drive_set = 1;
        end
        if (cm_phase == PH_ALIGN) begin
          if (cm_align_cnt < r_align) cm_align_cnt = cm_align_cnt + 8'd1;
          if (cm_align_cnt >= r_align) begin
            cm_align_cnt = '0;
            if (cm_step == 3'd3 || cm_step == 3'd4) begin
              cm_step = cm_step + 3'd1;
            end else begin
              cm_step = 3'd0; cm_on_time = ON_RUN_T; cm_phase = PH_RAMP; restart = 1;
            end
          end
        end
      end
      OP_SAMPLE: begin
        if (cm_phase == PH_RAMP || cm_phase == PH_CALIBRATE || cm_phase == PH_REGULATE) begin
          sel = it.bemf_bits[cm_step % 3];
          if (sel != cm_last_bemf) begin
            cm_last_bemf = sel;
            cm_step = (cm_step == 3'd5) ? 3'd0 : cm_step + 3'd1;
            comm = 1;
            if (cm_phase == PH_RAMP) begin
              if (cm_period > r_target) begin
                cm_period = cm_period - 16'd1;
              end else begin
                cm_phase = PH_CALIBRATE; restart = 1;
              end
            end else begin
              if (cm_phase == PH_CALIBRATE) begin
                if (in_window(cm_ref, it.elapsed)) cm_phase = PH_REGULATE;
                else cm_ref = cm_ref - 16'd1;
              end else if (cm_ref >= REG_SPAN && it.elapsed > cm_ref - REG_SPAN) begin
                nudge_on_time(1);
              end else if (it.elapsed < cm_ref) begin
                nudge_on_time(0);
              end else begin
                cm_on_time = ON_RUN_T;
              end
              restart = 1;
            end
          end
        end
      end
      default: ;
    endcase
    if (!drive_set) drive = (cm_phase != PH_IDLE) ? drive_for(cm_step) : 6'h00;
    res.phase           = cm_phase;
    res.step            = cm_step;
    res.drive_mask      = drive;
    res.on_time         = cm_on_time;
    res.pwm_period      = cm_period;
    res.commutated      = comm;
    res.restart_elapsed = restart;
  endtask

  // One request through the input channel, with random idle cycles ahead of it
  task automatic send_item(input in_req_t it);
    out_req_t res;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_commutator(it, res);
    predicted_reports.push_back(res);
  endtask

  // Wait for every outstanding result, then let the pipeline empty
  task automatic settle();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (predicted_reports.size() != 0) @(posedge clk);
    repeat (LATENCY_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TARGET_PERIOD: r_target = v;
      CFG_START_PERIOD:  r_start  = v;
      CFG_ALIGN_TICKS:   r_align  = v[7:0];
      default:           r_update = v[7:0];
    endcase
  endtask

  function automatic in_req_t item_of(op_t op, logic [2:0] bits, logic [15:0] e);
    in_req_t it;
    it.op = op; it.bemf_bits = bits; it.elapsed = e;
    return it;
  endfunction

  // Back-EMF sample whose selected comparator bit toggles or holds
  function automatic in_req_t sample_item(bit toggle, logic [15:0] e);
    logic [2:0] bits;
    bits = 3'($urandom_range(7));
    bits[cm_step % 3] = toggle ? ~cm_last_bemf : cm_last_bemf;
    return item_of(OP_SAMPLE, bits, e);
  endfunction

  // Requests that never commutate: ticks, held samples, late starts, unused op
  task automatic send_noise();
    logic [2:0]  bits;
    logic [15:0] e;
    bits = 3'($urandom_range(7));
    e    = 16'($urandom_range(65535));
    case ($urandom_range(3))
      0:       send_item(item_of(OP_TICK, bits, e));
      1:       send_item(sample_item(0, e));
      2:       send_item(item_of(OP_START, bits, e));
      default: send_item(item_of(OP_NONE, bits, e));
    endcase
  endtask

  // Elapsed value that keeps calibration from holding
  function automatic logic [15:0] calibrate_miss();
    logic [15:0] e;
    case ($urandom_range(3))
      0:       e = 16'($urandom_range(4));
      1:       e = (cm_ref <= 16'd65530) ? cm_ref + 16'd5 : 16'd0;
      2:       e = (cm_ref >= 16'd5) ? cm_ref - 16'd5 : 16'd1;
      default: e = 16'($urandom_range(65535));
    endcase
    while (in_window(cm_ref, e)) e = 16'($urandom_range(65535));
    return e;
  endfunction

  // Elapsed value aimed at the increase, decrease or reset branch of regulation
  function automatic logic [15:0] regulate_elapsed(bit push_up);
    int lo, hi;
    if ($urandom_range(9) == 0) return 16'($urandom_range(65535));
    if (push_up) begin
      lo = (cm_ref >= REG_SPAN) ? cm_ref - 99 : cm_ref;
      return ($urandom_range(7) == 0) ? 16'(lo) : 16'($urandom_range(65535, lo));
    end
    hi = (cm_ref >= REG_SPAN) ? cm_ref - REG_SPAN : cm_ref - 1;
    return ($urandom_range(7) == 0) ? 16'(hi) : 16'($urandom_range(hi, 0));
  endfunction

  // Events in idle, then register extremes before the motor starts
  task automatic test_idle_events();
    send_item(item_of(OP_TICK, 3'b111, 16'hFFFF));
    send_item(item_of(OP_SAMPLE, 3'b111, 16'hFFFF));
    send_item(item_of(OP_SAMPLE, 3'b000, 16'h0000));
    send_item(item_of(OP_NONE, 3'b101, 16'h5A5A));
    settle();
    write_reg(CFG_START_PERIOD, 16'hFFFF);
    write_reg(CFG_TARGET_PERIOD, 16'h0000);
    write_reg(CFG_ALIGN_TICKS, 16'h00FF);
    write_reg(CFG_UPDATE_EVERY, 16'h0000);
    send_item(item_of(OP_TICK, 3'b010, 16'h8000));
    settle();
    write_reg(CFG_START_PERIOD, 16'($urandom_range(60, 30)));
    write_reg(CFG_TARGET_PERIOD, 16'($urandom_range(20, 5)));
    write_reg(CFG_ALIGN_TICKS, 16'd2);
  endtask

  // Alignment through steps 3..5 with the tick count changed between steps
  task automatic test_alignment();
    send_item(item_of(OP_START, 3'b000, 16'h0000));
    send_item(item_of(OP_START, 3'b111, 16'hFFFF));
    send_item(sample_item(1, 16'h1234));
    send_item(item_of(OP_NONE, 3'b111, 16'hFFFF));
    send_item(item_of(OP_TICK, 3'b000, 16'h0000));
    send_item(item_of(OP_TICK, 3'b000, 16'h0000));
    settle();
    // zero ticks: the next tick ends the step at once
    write_reg(CFG_ALIGN_TICKS, 16'h0000);
    send_item(item_of(OP_TICK, 3'b001, 16'h0001));
    settle();
    write_reg(CFG_ALIGN_TICKS, 16'hFFFF);
    send_item(item_of(OP_TICK, 3'b100, 16'h0002));
    send_item(item_of(OP_TICK, 3'b100, 16'h0003));
    settle();
    // count already past the new limit: alignment finishes
    write_reg(CFG_ALIGN_TICKS, 16'h0001);
    send_item(item_of(OP_TICK, 3'b110, 16'h0004));
  endtask

  task automatic drive_ramp(int turns);
    int done;
    done = 0;
    while (done < turns && cm_phase == PH_RAMP) begin
      if ($urandom_range(4) == 0) begin
        send_noise();
      end else begin
        send_item(sample_item(1, 16'($urandom_range(65535))));
        done++;
      end
    end
  endtask

  // Speed ramp, with the target dropped to zero part of the way
  task automatic test_ramp();
    logic [15:0] keep_target;
    keep_target = r_target;
    set_idling(0);
    drive_ramp(8);
    settle();
    write_reg(CFG_TARGET_PERIOD, 16'h0000);
    set_idling(1);
    drive_ramp(4);
    settle();
    write_reg(CFG_TARGET_PERIOD, keep_target);
    set_idling(2);
    drive_ramp(1000);
  endtask

  // Walk the reference interval a short way down to a landing point
  task automatic test_calibrate();
    int goal, hi, turns;
    logic [15:0] e;
    goal = int'(cm_ref) - int'($urandom_range(250, 150));
    turns = 0;
    while (cm_phase == PH_CALIBRATE) begin
      set_idling(turns < 70 ? 0 : (turns < 140 ? 1 : 2));
      if ($urandom_range(9) < 2) begin
        send_noise();
      end else begin
        if (int'(cm_ref) == goal) begin
          hi = 65535 - goal;
          if (hi > 4) hi = 4;
          e = 16'(goal - 4 + int'($urandom_range(hi + 4)));
        end else begin
          e = calibrate_miss();
        end
        send_item(sample_item(1, e));
        turns++;
      end
    end
  endtask

  // On-time regulation in batches, each with its own update rate and bias
  task automatic test_regulate();
    logic [15:0] rates [9];
    bit up_bias;
    rates = '{16'h0001, 16'h0001, 16'hFF00, 16'h00FF, 16'h0002, 16'hA503, 16'h0001,
              16'h0000, 16'h0001};
    rates[7] = 16'($urandom_range(65535));
    for (int b = 0; b < 9; b++) begin
      settle();
      write_reg(CFG_UPDATE_EVERY, rates[b]);
      if (b == 0) begin
        write_reg(CFG_TARGET_PERIOD, 16'hFFFF);
        write_reg(CFG_START_PERIOD, 16'h0000);
        write_reg(CFG_ALIGN_TICKS, 16'($urandom_range(65535)));
      end else if (b == 4) begin
        write_reg(CFG_TARGET_PERIOD, 16'($urandom_range(65535)));
        write_reg(CFG_START_PERIOD, 16'($urandom_range(65535)));
      end
      set_idling(b % 3);
      for (int n = 0; n < 170; n++) begin
        if ($urandom_range(99) < 15) begin
          send_noise();
        end else begin
          up_bias = (b % 2 == 0) ? ($urandom_range(99) < 95) : ($urandom_range(99) < 20);
          send_item(sample_item(1, regulate_elapsed(up_bias)));
        end
      end
    end
  endtask

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  // Compare every accepted result with the oldest prediction
  always @(posedge clk) begin : check_reports
    out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_reports.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %h", $time, out_data);
      end else begin
        want = predicted_reports.pop_front();
        if (out_data.phase !== want.phase)
          flag_mismatch("phase", 32'(want.phase), 32'(out_data.phase));
        if (out_data.step !== want.step)
          flag_mismatch("step", 32'(want.step), 32'(out_data.step));
        if (out_data.drive_mask !== want.drive_mask)
          flag_mismatch("drive_mask", 32'(want.drive_mask), 32'(out_data.drive_mask));
        if (out_data.on_time !== want.on_time)
          flag_mismatch("on_time", 32'(want.on_time), 32'(out_data.on_time));
        if (out_data.pwm_period !== want.pwm_period)
          flag_mismatch("pwm_period", 32'(want.pwm_period), 32'(out_data.pwm_period));
        if (out_data.commutated !== want.commutated)
          flag_mismatch("commutated", 32'(want.commutated), 32'(out_data.commutated));
        if (out_data.restart_elapsed !== want.restart_elapsed)
          flag_mismatch("restart_elapsed", 32'(want.restart_elapsed),
                        32'(out_data.restart_elapsed));
      end
    end
  end

  initial begin
    reset_model();
    set_idling(0);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_events();
    test_alignment();
    test_ramp();
    test_calibrate();
    test_regulate();
    settle();
    if (mismatches == 0 && predicted_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 10);
    $display("status: fail");
    $finish;
  end

endmodule
